// File: rtl/sbis_pkg.sv
// Package: shared constants, codes and item types for the sorted byte store.
package sbis_pkg;

    // Store geometry
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = 6;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QP_W   = $clog2(QDEPTH);

    // Command codes of an input item
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Operation kinds handed from front to back
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_op;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

endpackage

// File: rtl/sbis_front.sv
// Front end: accepts items, decodes the command and queues the operation.
module sbis_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  sbis_pkg::t_in_item  i_item,
    output logic                busy,
    output sbis_pkg::t_q_head   o_head,
    input  logic                i_pop
);

    sbis_pkg::t_op                  r_q [sbis_pkg::QDEPTH];
    logic [sbis_pkg::QP_W-1:0]      r_wr;
    logic [sbis_pkg::QP_W-1:0]      r_rd;
    logic [sbis_pkg::QP_W:0]        r_cnt;
    logic                           push;
    logic                           pop;
    sbis_pkg::t_op                  dec_op;

    assign busy = (r_cnt == (sbis_pkg::QP_W+1)'(sbis_pkg::QDEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != '0);

    // Command decode
    always_comb begin
        dec_op.value = i_item.value;
        unique case (i_item.cmd)
            sbis_pkg::CMD_INSERT: dec_op.kind = sbis_pkg::OP_INSERT;
            sbis_pkg::CMD_READ:   dec_op.kind = sbis_pkg::OP_READ;
            sbis_pkg::CMD_CLEAR:  dec_op.kind = sbis_pkg::OP_CLEAR;
            default:              dec_op.kind = sbis_pkg::OP_NOP;
        endcase
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec_op;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.op    = r_q[r_rd];

endmodule

// File: rtl/sbis_back.sv
// Back end: sorted cell chain, readout sequencer and result register.
module sbis_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbis_pkg::t_q_head    i_head,
    output logic                 o_pop,
    output logic                 o_strobe,
    output sbis_pkg::t_out_item  o_result
);

    logic [7:0]                   r_cells [sbis_pkg::DEPTH];
    logic [sbis_pkg::CNT_W-1:0]   r_fill;
    logic                         r_reading;
    logic [sbis_pkg::IDX_W-1:0]   r_rd_idx;
    logic                         r_strobe;
    sbis_pkg::t_out_item          r_result;

    logic [sbis_pkg::CNT_W-1:0]   n_fill;
    logic                         n_reading;
    logic [sbis_pkg::IDX_W-1:0]   n_rd_idx;
    logic                         n_strobe;
    sbis_pkg::t_out_item          n_result;

    logic                         full;
    logic                         do_insert;
    logic                         rd_last;
    logic [sbis_pkg::DEPTH-1:0]   lt;

    assign o_pop   = i_head.valid && !r_reading;
    assign full    = (r_fill == sbis_pkg::CNT_W'(sbis_pkg::DEPTH));
    assign rd_last = ((sbis_pkg::CNT_W'(r_rd_idx) + 1'b1) == r_fill);
    assign do_insert = o_pop && (i_head.op.kind == sbis_pkg::OP_INSERT) && !full;

    // Per-cell compare: cell holds a stored value smaller than the new byte
    always_comb begin
        for (int i = 0; i < sbis_pkg::DEPTH; i++) begin
            lt[i] = (sbis_pkg::CNT_W'(i) < r_fill) && (r_cells[i] < i_head.op.value);
        end
    end

    // Cell chain: keep below the slot, load at the slot, shift up above it
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            if (!lt[0]) begin
                r_cells[0] <= i_head.op.value;
            end
            for (int i = 1; i < sbis_pkg::DEPTH; i++) begin
                if (lt[i]) begin
                    r_cells[i] <= r_cells[i];
                end else if (lt[i-1]) begin
                    r_cells[i] <= i_head.op.value;
                end else begin
                    r_cells[i] <= r_cells[i-1];
                end
            end
        end
    end

    // Operation sequencing and result formation
    always_comb begin
        n_fill    = r_fill;
        n_reading = r_reading;
        n_rd_idx  = r_rd_idx;
        n_strobe  = 1'b0;
        n_result.data_byte = 8'd0;
        n_result.last      = 1'b1;
        n_result.status    = sbis_pkg::ST_OK;
        n_result.count     = r_fill;
        if (r_reading) begin
            n_strobe = 1'b1;
            n_result.data_byte = r_cells[r_rd_idx];
            n_result.last      = rd_last;
            n_rd_idx           = r_rd_idx + 1'b1;
            if (rd_last) begin
                n_reading = 1'b0;
            end
        end else if (o_pop) begin
            n_strobe = 1'b1;
            unique case (i_head.op.kind)
                sbis_pkg::OP_INSERT: begin
                    if (full) begin
                        n_result.status = sbis_pkg::ST_FULL;
                    end else begin
                        n_fill         = r_fill + 1'b1;
                        n_result.count = r_fill + 1'b1;
                    end
                end
                sbis_pkg::OP_READ: begin
                    if (r_fill == '0) begin
                        n_result.status = sbis_pkg::ST_EMPTY;
                    end else begin
                        n_strobe  = 1'b0;
                        n_reading = 1'b1;
                        n_rd_idx  = '0;
                    end
                end
                sbis_pkg::OP_CLEAR: begin
                    n_fill         = '0;
                    n_result.count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_reading <= 1'b0;
            r_rd_idx  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_reading <= n_reading;
            r_rd_idx  <= n_rd_idx;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: rtl/sorted_byte_insertion_store_top.sv
// Sorted byte store with insert, ordered readout and clear commands.
// An item is taken when start is high and busy is low. Results leave on o_result with
// o_strobe high for one cycle each and cannot be held off. A decoded command waits in a
// four-entry queue; the back end takes one command per cycle while no read is in progress,
// so inserts, clears and unused codes sustain one item per cycle, each result leaving
// through the result register. A read of N stored bytes occupies the back end for a start
// step and then the readout of each byte in turn; further items meanwhile fill the queue and
// busy rises once it holds four. The store holds 32 bytes and needs no clearing pass.
module sorted_byte_insertion_store_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  sbis_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output sbis_pkg::t_out_item  o_result
);

    sbis_pkg::t_q_head head;
    logic              pop;

    sbis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    sbis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
